[src/mma_pkg.sv]
// Shared types and MIDI status codes for the MIDI message assembler.
// No dependencies; used by mma_step and midi_message_assembler_core.
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

  // Status nibbles of the channel messages and of the system messages.
  localparam logic [3:0] NIB_NOTE_OFF     = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON      = 4'h9;
  localparam logic [3:0] NIB_AFTERTOUCH   = 4'hA;
  localparam logic [3:0] NIB_CONTROL      = 4'hB;
  localparam logic [3:0] NIB_PROGRAM      = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS   = 4'hD;
  localparam logic [3:0] NIB_PITCH_WHEEL  = 4'hE;
  localparam logic [3:0] NIB_SYSTEM       = 4'hF;

  // System status bytes.
  localparam logic [7:0] SYSEX_START      = 8'hF0;
  localparam logic [7:0] SONG_POSITION    = 8'hF2;
  localparam logic [7:0] SYSEX_END        = 8'hF7;
  localparam logic [7:0] TIMING_CLOCK     = 8'hF8;
  localparam logic [7:0] SYSTEM_RESET     = 8'hFF;

  // Highest low nibble of a system status that becomes running status.
  localparam logic [3:0] SYS_COMMON_LAST  = 4'h3;

  typedef struct packed {
    logic [7:0] running_status;
    logic       status_valid;
    logic       byte_position;
    logic [6:0] held0;
    logic [6:0] held1;
  } mma_state_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] first;
    logic [6:0] second;
  } mma_msg_t;

endpackage

`default_nettype wire

[src/mma_step.sv]
// Next-state and result logic of the MIDI message assembler for one byte.
// Depends on mma_pkg for the state and message types and the status codes.
`timescale 1ns / 1ps
`default_nettype none

module mma_step (
  input  var mma_pkg::mma_state_t state_i,
  input  wire logic [7:0]         midi_byte_i,
  output mma_pkg::mma_state_t     state_o,
  output logic                    res_valid_o,
  output mma_pkg::mma_msg_t       res_o
);

  logic [3:0] byte_hi;
  logic [3:0] byte_lo;
  logic [3:0] rs_hi;
  logic [6:0] data;

  assign byte_hi = midi_byte_i[7:4];
  assign byte_lo = midi_byte_i[3:0];
  assign rs_hi   = state_i.running_status[7:4];
  assign data    = midi_byte_i[6:0];

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (midi_byte_i[7]) begin
      // Status byte. A system byte above F3 only takes over when no command is held.
      if (byte_hi != mma_pkg::NIB_SYSTEM || !state_i.status_valid) begin
        state_o.running_status = midi_byte_i;
        state_o.status_valid   = 1'b1;
      end
      state_o.held0 = '0;
      state_o.held1 = '0;

      if (byte_hi != mma_pkg::NIB_SYSTEM) begin
        state_o.byte_position = 1'b0;
      end else if (byte_lo <= mma_pkg::SYS_COMMON_LAST) begin
        state_o.running_status = midi_byte_i;
        state_o.status_valid   = 1'b1;
        state_o.byte_position  = 1'b0;
      end else if (midi_byte_i == mma_pkg::SYSEX_END) begin
        if (state_o.status_valid && state_o.running_status == mma_pkg::SYSEX_START) begin
          state_o.status_valid = 1'b0;
        end
      end else if (midi_byte_i == mma_pkg::TIMING_CLOCK) begin
        res_valid_o  = 1'b1;
        res_o.status = mma_pkg::TIMING_CLOCK;
      end else if (midi_byte_i == mma_pkg::SYSTEM_RESET) begin
        state_o.running_status = '0;
        state_o.status_valid   = 1'b0;
        state_o.byte_position  = 1'b0;
      end
    end else if (state_i.status_valid) begin
      unique case (rs_hi) inside
        mma_pkg::NIB_NOTE_OFF, mma_pkg::NIB_NOTE_ON, mma_pkg::NIB_AFTERTOUCH,
        mma_pkg::NIB_CONTROL, mma_pkg::NIB_PITCH_WHEEL: begin
          if (state_i.byte_position) begin
            state_o.held1         = data;
            state_o.byte_position = 1'b0;
            res_valid_o           = 1'b1;
            res_o.status          = state_i.running_status;
            res_o.first           = state_i.held0;
            res_o.second          = data;
          end else begin
            state_o.held0         = data;
            state_o.byte_position = 1'b1;
          end
        end
        mma_pkg::NIB_PROGRAM, mma_pkg::NIB_CHAN_PRESS: begin
          state_o.held0 = data;
          res_valid_o   = 1'b1;
          res_o.status  = state_i.running_status;
          res_o.first   = data;
          res_o.second  = state_i.held1;
        end
        mma_pkg::NIB_SYSTEM: begin
          // Song position collects its two bytes without a result.
          if (state_i.running_status == mma_pkg::SONG_POSITION) begin
            if (state_i.byte_position) begin
              state_o.held1 = data;
            end else begin
              state_o.held0 = data;
            end
            state_o.byte_position = !state_i.byte_position;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/midi_message_assembler_core.sv]
// Top level of the MIDI message assembler: state registers, output register
// and skid stage. Depends on mma_pkg and mma_step.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   midi_byte_i (8)
// result    out        out_valid_o / out_stall_i message_status_o (8), first_data_o (7),
//                                                second_data_o (7)
//
// One byte is taken per cycle unless stalled. Its result, if any, appears on the output
// register the next cycle when that register is free or being read;
// otherwise it waits in the skid stage. The parser state updates in the
// same cycle the byte is taken, so a byte depends only on the state left by
// the one before. A two-entry output (register plus skid) lets input continue
// while a result waits; in_stall_o rises only when both are full. Reset
// clears the parser state and both output valid flags.

module midi_message_assembler_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] midi_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      message_status_o,
  output logic [6:0]      first_data_o,
  output logic [6:0]      second_data_o
);

  mma_pkg::mma_state_t state_q;
  mma_pkg::mma_state_t state_d;
  mma_pkg::mma_msg_t   res;
  logic                res_valid;
  mma_pkg::mma_msg_t   out_q;
  logic                out_valid_q;
  mma_pkg::mma_msg_t   skid_q;
  logic                skid_valid_q;
  logic                in_take;
  logic                out_take;
  logic                res_push;

  mma_step u_step (
    .state_i     (state_q),
    .midi_byte_i (midi_byte_i),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_stall_o = skid_valid_q;
  assign in_take    = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;
  assign res_push   = in_take && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_take) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      // The skid item goes out first; no new item is taken while it is held.
      out_valid_q  <= skid_valid_q || res_push;
      skid_valid_q <= 1'b0;
    end else if (res_push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign message_status_o = out_q.status;
  assign first_data_o     = out_q.first;
  assign second_data_o    = out_q.second;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for midi_message_assembler_core: a directed table, then random
// MIDI byte streams, checked against a running-status message predictor.
// Depends on mma_pkg and the RTL of midi_message_assembler_core.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIRECTED_LEN = 28;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_TYPED
  } check_e;

  typedef struct {
    logic [7:0]        midi;
    check_e            chk;
    mma_pkg::mma_msg_t msg;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] midi_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] message_status_o;
  logic [6:0] first_data_o;
  logic [6:0] second_data_o;

  midi_message_assembler_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .midi_byte_i     (midi_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .message_status_o(message_status_o),
    .first_data_o    (first_data_o),
    .second_data_o   (second_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Parser state mirrored by the predictor.
  logic [7:0] cur_status;
  logic       have_status;
  logic       data_slot;
  logic [6:0] held_first;
  logic [6:0] held_second;

  stim_row_t         directed_rows [DIRECTED_LEN];
  stim_row_t         stim_q[$];
  stim_row_t         cur_row;
  mma_pkg::mma_msg_t pending_msgs[$];
  mma_pkg::mma_msg_t predicted_msg;
  mma_pkg::mma_msg_t want;
  logic              predicted_fire;
  int                total_items;
  int                items_taken;
  int                mismatch_count;
  int                cycle_count;

  task automatic assemble_byte(input logic [7:0] b, output logic fired,
                               output mma_pkg::mma_msg_t msg);
    fired = 1'b0;
    msg = '0;
    if (b[7]) begin
      if (b[7:4] != mma_pkg::NIB_SYSTEM || !have_status) begin
        cur_status = b;
        have_status = 1'b1;
      end
      held_first = '0;
      held_second = '0;
      if (b[7:4] != mma_pkg::NIB_SYSTEM) begin
        data_slot = 1'b0;
      end else if (b[3:0] <= mma_pkg::SYS_COMMON_LAST) begin
        cur_status = b;
        have_status = 1'b1;
        data_slot = 1'b0;
      end else if (b == mma_pkg::SYSEX_END) begin
        if (have_status && cur_status == mma_pkg::SYSEX_START) have_status = 1'b0;
      end else if (b == mma_pkg::TIMING_CLOCK) begin
        fired = 1'b1;
        msg.status = mma_pkg::TIMING_CLOCK;
      end else if (b == mma_pkg::SYSTEM_RESET) begin
        cur_status = '0;
        have_status = 1'b0;
        data_slot = 1'b0;
      end
    end else if (have_status) begin
      case (cur_status[7:4])
        mma_pkg::NIB_NOTE_OFF, mma_pkg::NIB_NOTE_ON, mma_pkg::NIB_AFTERTOUCH,
        mma_pkg::NIB_CONTROL, mma_pkg::NIB_PITCH_WHEEL: begin
          if (data_slot) begin
            held_second = b[6:0];
            data_slot = 1'b0;
            fired = 1'b1;
            msg = '{cur_status, held_first, held_second};
          end else begin
            held_first = b[6:0];
            data_slot = 1'b1;
          end
        end
        mma_pkg::NIB_PROGRAM, mma_pkg::NIB_CHAN_PRESS: begin
          held_first = b[6:0];
          fired = 1'b1;
          msg = '{cur_status, held_first, held_second};
        end
        mma_pkg::NIB_SYSTEM: begin
          // Song position swallows its two data bytes without a message.
          if (cur_status == mma_pkg::SONG_POSITION) begin
            if (data_slot) held_second = b[6:0];
            else held_first = b[6:0];
            data_slot = ~data_slot;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    stim_row_t row;
    row.midi = b;
    row.chk = CHK_MODEL;
    row.msg = '0;
    stim_q.push_back(row);
  endtask

  function automatic logic [7:0] random_data();
    return {1'b0, 7'($urandom_range(127))};
  endfunction

  // Mostly well-formed messages with random content, some broken ones and noise.
  task automatic build_random_stream();
    int         kind;
    int         n_data;
    logic [3:0] nib;
    while (stim_q.size() < DIRECTED_LEN + RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        nib = mma_pkg::NIB_NOTE_OFF + 4'($urandom_range(6));
        add_byte({nib, 4'($urandom_range(15))});
        n_data = (nib == mma_pkg::NIB_PROGRAM || nib == mma_pkg::NIB_CHAN_PRESS) ? 1 : 2;
        repeat (n_data * $urandom_range(1, 4)) begin
          // A realtime byte may land anywhere inside the message.
          if ($urandom_range(99) < 8) begin
            add_byte({mma_pkg::NIB_SYSTEM, 4'($urandom_range(15, 8))});
          end
          add_byte(random_data());
        end
      end else if (kind < 60) begin
        add_byte(mma_pkg::SONG_POSITION);
        repeat (2) add_byte(random_data());
      end else if (kind < 68) begin
        add_byte(mma_pkg::SYSEX_START);
        repeat ($urandom_range(4)) add_byte(random_data());
        if ($urandom_range(3) != 0) add_byte(mma_pkg::SYSEX_END);
      end else if (kind < 73) begin
        add_byte({mma_pkg::NIB_SYSTEM, 4'($urandom_range(mma_pkg::SYS_COMMON_LAST))});
        add_byte(random_data());
      end else if (kind < 78) begin
        add_byte({mma_pkg::NIB_SYSTEM, 4'($urandom_range(15, 4))});
      end else if (kind < 81) begin
        add_byte(mma_pkg::SYSTEM_RESET);
      end else if (kind < 90) begin
        add_byte({mma_pkg::NIB_NOTE_OFF + 4'($urandom_range(6)), 4'($urandom_range(15))});
        add_byte(random_data());
      end else begin
        repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
      end
    end
  endtask

  function automatic int gap_percent(input logic rx_side);
    if (items_taken * 3 < total_items) return rx_side ? 52 : 31;
    if (items_taken * 3 < total_items * 2) return rx_side ? 31 : 52;
    return 0;
  endfunction

  // Input side: present the next item once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        assemble_byte(cur_row.midi, predicted_fire, predicted_msg);
        items_taken++;
        case (cur_row.chk)
          CHK_MODEL: if (predicted_fire) pending_msgs.push_back(predicted_msg);
          CHK_TYPED: pending_msgs.push_back(cur_row.msg);
          default: ;
        endcase
      end
      if (!in_valid_i || !in_stall_o) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= gap_percent(1'b0)) begin
          cur_row = stim_q.pop_front();
          in_valid_i <= 1'b1;
          midi_byte_i <= cur_row.midi;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: random stall, compare each taken message with the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_msgs.size() == 0) begin
          $display("%0t: unexpected message %h %h %h", $time, message_status_o,
                   first_data_o, second_data_o);
          mismatch_count++;
        end else begin
          want = pending_msgs.pop_front();
          if (want.status != message_status_o) begin
            $display("%0t: message_status expected %h actual %h", $time, want.status,
                     message_status_o);
            mismatch_count++;
          end
          if (want.first != first_data_o) begin
            $display("%0t: first_data expected %h actual %h", $time, want.first,
                     first_data_o);
            mismatch_count++;
          end
          if (want.second != second_data_o) begin
            $display("%0t: second_data expected %h actual %h", $time, want.second,
                     second_data_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < gap_percent(1'b1));
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    cur_status = '0;
    have_status = 1'b0;
    data_slot = 1'b0;
    held_first = '0;
    held_second = '0;
    items_taken = 0;
    mismatch_count = 0;
    directed_rows = '{
      '{8'h00, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},  // data byte with no command
      '{8'hF4, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h55, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h90, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h7F, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h00, CHK_TYPED, '{8'h90, 7'h7F, 7'h00}},
      '{8'hC5, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h7F, CHK_TYPED, '{8'hC5, 7'h7F, 7'h00}},
      '{8'hDF, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h40, CHK_TYPED, '{8'hDF, 7'h40, 7'h00}},
      // A clock inside a note off clears the held bytes but keeps the position.
      '{8'h80, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h01, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'hF8, CHK_TYPED, '{8'hF8, 7'h00, 7'h00}},
      '{8'h02, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'hA3, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h12, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h34, CHK_TYPED, '{8'hA3, 7'h12, 7'h34}},
      '{8'hE0, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h00, CHK_NONE,  '{8'h00, 7'h00, 7'h00}},
      '{8'h40, CHK_TYPED, '{8'hE0, 7'h00, 7'h40}},
      '{8'hF2, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'h10, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'h20, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'hF0, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'h11, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'hF7, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'h22, CHK_MODEL, '{8'h00, 7'h00, 7'h00}},
      '{8'hFF, CHK_MODEL, '{8'h00, 7'h00, 7'h00}}
    };
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
    build_random_stream();
    total_items = stim_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < total_items) @(posedge clk_i);
    while (pending_msgs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/mma_pkg.sv
src/mma_step.sv
src/midi_message_assembler_core.sv
tb/testbench.sv
